// ===== src/iirbe_pkg.sv =====
`timescale 1ns / 1ps
package iirbe_pkg;

    localparam int BANDS = 10;
    localparam int ORDER = 2;
    localparam int NTAPS = 2 * ORDER + 1;
    localparam int HIST  = 2 * ORDER;

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int HW  = $clog2(HIST);
    localparam int SW  = $clog2(NTAPS + HIST + 1);
    localparam int CAW = BW + SW;
    localparam int HAW = BW + HW;
    localparam int CDEPTH = BANDS << SW;
    localparam int HDEPTH = BANDS << HW;

    // per-band operation sequence: feed-forward taps, feedback taps, gain load,
    // low and high gain products
    localparam int OP_FB   = NTAPS;
    localparam int OP_GAIN = NTAPS + HIST;
    localparam int OP_GLO  = OP_GAIN + 1;
    localparam int OP_GHI  = OP_GAIN + 2;
    localparam int NOPS    = OP_GAIN + 3;
    localparam int OW      = $clog2(NOPS);

    localparam logic [1:0] FUNC_FILT = 2'd0;
    localparam logic [1:0] FUNC_FF   = 2'd1;
    localparam logic [1:0] FUNC_FB   = 2'd2;
    localparam logic [1:0] FUNC_GAIN = 2'd3;

    typedef struct packed {
        logic          vld;
        logic          last;
        logic [BW-1:0] band;
        logic [OW-1:0] op;
    } t_tag;

    typedef struct packed {
        logic               vld;
        logic [BW-1:0]      band;
        logic signed [31:0] y;
    } t_ywr;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] sample;
        logic               clipped;
    } t_res;

endpackage

// ===== src/iir_band_filter_bank_equalizer.sv =====
`timescale 1ns / 1ps
// channel  | handshake          | payload
// input    | i_valid / o_ready  | i_func i_sample_in i_band_index i_tap_index
//          |                    | i_coeff_value i_gain_value
// output   | o_valid / i_ready  | o_sample_out o_clipped
//
// A filter item runs all bands through the one shared multiplier and the
// coefficient RAM port; no new item is accepted until its result has moved
// on to the output register. Coefficient and gain writes give no item.
// After reset a clearing pass zeroes both RAMs; no item is accepted meanwhile.
// A finished result waits in a holding register while the output stalls.
module iir_band_filter_bank_equalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_sample_in,
    input  logic [3:0]         i_band_index,
    input  logic [2:0]         i_tap_index,
    input  logic signed [23:0] i_coeff_value,
    input  logic [15:0]        i_gain_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample_out,
    output logic               o_clipped
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state r_state;
    logic [iirbe_pkg::CAW-1:0] r_clr;
    logic [iirbe_pkg::BW-1:0]  r_band;
    logic [iirbe_pkg::OW-1:0]  r_op;
    logic [iirbe_pkg::HW-1:0]  r_ptr;
    iirbe_pkg::t_tag           r_tag;
    logic                      r_fin_vld;
    logic signed [15:0]        r_fin_sample;
    logic                      r_fin_clipped;
    logic                      r_out_vld;
    logic signed [15:0]        r_out_sample;
    logic                      r_out_clipped;

    logic s_acc, s_start, s_move, s_last_op;
    logic [iirbe_pkg::SW-1:0]  s_wslot, s_rslot;
    logic                      s_cwe_ok;
    logic [23:0]               s_cwdata;
    logic                      c_we;
    logic [iirbe_pkg::CAW-1:0] c_waddr, c_raddr;
    logic [23:0]               c_wdata, c_q;
    logic                      h_we;
    logic [iirbe_pkg::HAW-1:0] h_waddr, h_raddr;
    logic [31:0]               h_wdata, h_q;
    logic [iirbe_pkg::HW:0]    s_hsum;
    logic [iirbe_pkg::HW-1:0]  s_hslot, s_wrslot;
    logic [iirbe_pkg::OW-1:0]  s_hc;
    iirbe_pkg::t_ywr           s_ywr;
    iirbe_pkg::t_res           s_res;

    assign o_ready   = (r_state == ST_IDLE);
    assign s_acc     = i_valid && o_ready;
    assign s_start   = s_acc && (i_func == iirbe_pkg::FUNC_FILT);
    assign s_last_op = (r_op == iirbe_pkg::OW'(iirbe_pkg::NOPS - 1));
    assign s_move    = r_fin_vld && (!r_out_vld || i_ready);

    // coefficient write decode
    always_comb begin
        s_wslot  = iirbe_pkg::SW'(i_tap_index);
        s_cwe_ok = 1'b0;
        s_cwdata = i_coeff_value;
        case (i_func)
            iirbe_pkg::FUNC_FF: begin
                s_cwe_ok = (i_tap_index < 3'(iirbe_pkg::NTAPS));
            end
            iirbe_pkg::FUNC_FB: begin
                s_wslot  = iirbe_pkg::SW'(i_tap_index) + iirbe_pkg::SW'(iirbe_pkg::NTAPS - 1);
                s_cwe_ok = (i_tap_index != 3'd0) && (i_tap_index <= 3'(iirbe_pkg::HIST));
            end
            iirbe_pkg::FUNC_GAIN: begin
                s_wslot  = iirbe_pkg::SW'(iirbe_pkg::OP_GAIN);
                s_cwe_ok = 1'b1;
                s_cwdata = {8'b0, i_gain_value};
            end
            default: begin
                s_cwe_ok = 1'b0;
            end
        endcase
        s_cwe_ok = s_cwe_ok && (5'(i_band_index) < 5'(iirbe_pkg::BANDS));
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = r_clr;
            c_wdata = '0;
        end else begin
            c_we    = s_acc && s_cwe_ok;
            c_waddr = {iirbe_pkg::BW'(i_band_index), s_wslot};
            c_wdata = s_cwdata;
        end
    end

    // history slot of feedback tap c: (ptr + c) mod HIST
    always_comb begin
        s_hc     = r_op - iirbe_pkg::OW'(iirbe_pkg::OP_FB);
        s_hsum   = {1'b0, r_ptr} + {1'b0, s_hc[iirbe_pkg::HW-1:0]};
        if (s_hsum >= (iirbe_pkg::HW+1)'(iirbe_pkg::HIST)) begin
            s_hsum = s_hsum - (iirbe_pkg::HW+1)'(iirbe_pkg::HIST);
        end
        s_hslot  = s_hsum[iirbe_pkg::HW-1:0];
        s_rslot  = (r_op > iirbe_pkg::OW'(iirbe_pkg::OP_GAIN))
                   ? iirbe_pkg::SW'(iirbe_pkg::OP_GAIN) : iirbe_pkg::SW'(r_op);
        s_wrslot = (r_ptr == '0) ? iirbe_pkg::HW'(iirbe_pkg::HIST - 1)
                                 : r_ptr - iirbe_pkg::HW'(1);
    end

    assign c_raddr = {r_band, s_rslot};
    assign h_raddr = {r_band, s_hslot};

    always_comb begin
        if (r_state == ST_CLEAR) begin
            h_we    = (r_clr < iirbe_pkg::CAW'(iirbe_pkg::HDEPTH));
            h_waddr = r_clr[iirbe_pkg::HAW-1:0];
            h_wdata = '0;
        end else begin
            h_we    = s_ywr.vld;
            h_waddr = {s_ywr.band, s_wrslot};
            h_wdata = s_ywr.y;
        end
    end

    iirbe_ram #(
        .W  (24),
        .D  (iirbe_pkg::CDEPTH),
        .AW (iirbe_pkg::CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_q)
    );

    iirbe_ram #(
        .W  (32),
        .D  (iirbe_pkg::HDEPTH),
        .AW (iirbe_pkg::HAW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    iirbe_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_start),
        .i_commit (s_move),
        .i_x      (i_sample_in),
        .i_tag    (r_tag),
        .i_coef   (c_q),
        .i_hist   (h_q),
        .o_ywr    (s_ywr),
        .o_res    (s_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_band    <= '0;
            r_op      <= '0;
            r_ptr     <= '0;
            r_tag     <= '0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + iirbe_pkg::CAW'(1);
                    if (r_clr == iirbe_pkg::CAW'(iirbe_pkg::CDEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_start) begin
                        r_band  <= '0;
                        r_op    <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (s_last_op) begin
                        r_op <= '0;
                        if (r_band == iirbe_pkg::BW'(iirbe_pkg::BANDS - 1)) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_band <= r_band + iirbe_pkg::BW'(1);
                        end
                    end else begin
                        r_op <= r_op + iirbe_pkg::OW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (s_move) begin
                        r_ptr   <= s_wrslot;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase

            // issue one operation tag per run cycle
            if (r_state == ST_RUN) begin
                r_tag <= '{vld:  1'b1,
                           last: (r_band == iirbe_pkg::BW'(iirbe_pkg::BANDS - 1)),
                           band: r_band,
                           op:   r_op};
            end else begin
                r_tag <= '0;
            end

            // hold the result until the output register is free
            if (s_res.vld) begin
                r_fin_vld <= 1'b1;
            end else if (s_move) begin
                r_fin_vld <= 1'b0;
            end
            if (s_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res.vld) begin
            r_fin_sample  <= s_res.sample;
            r_fin_clipped <= s_res.clipped;
        end
        if (s_move) begin
            r_out_sample  <= r_fin_sample;
            r_out_clipped <= r_fin_clipped;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clipped;

    a_ywr_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ywr.vld |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("band output written outside a filter item");

    a_no_fin_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.vld |-> !r_fin_vld)
        else $error("result overwrites a held result");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid)
        else $error("output valid during clearing pass");

    a_drain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.vld |-> (r_state == ST_DRAIN))
        else $error("result outside drain");

endmodule

// ===== src/iirbe_ram.sv =====
`timescale 1ns / 1ps
module iirbe_ram #(
    parameter int W  = 24,
    parameter int D  = 160,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== src/iirbe_mac.sv =====
`timescale 1ns / 1ps
module iirbe_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_commit,
    input  logic signed [15:0]   i_x,
    input  iirbe_pkg::t_tag      i_tag,
    input  logic signed [23:0]   i_coef,
    input  logic signed [31:0]   i_hist,
    output iirbe_pkg::t_ywr      o_ywr,
    output iirbe_pkg::t_res      o_res
);

    logic signed [15:0] r_x;
    logic signed [15:0] r_xh [iirbe_pkg::HIST];
    logic [15:0]        r_gain;

    logic signed [23:0] s_a;
    logic signed [31:0] s_b;
    logic [iirbe_pkg::OW-1:0] s_xi;

    logic signed [55:0] r_prod;
    iirbe_pkg::t_tag    r_t2, r_t3, r_t4, r_t5;
    logic               r_t6_last;
    logic signed [63:0] r_ff, r_fb, r_glo, r_gff, r_acc;
    logic signed [31:0] r_y;
    logic signed [39:0] r_total;

    logic signed [63:0] s_p64, s_yr;
    logic signed [39:0] s_tr;

    // operand select for the shared multiplier
    always_comb begin
        s_xi = i_tag.op - iirbe_pkg::OW'(1);
        s_a  = i_coef;
        s_b  = i_hist;
        if (i_tag.op == iirbe_pkg::OW'(0)) begin
            s_b = 32'(r_x);
        end else if (i_tag.op < iirbe_pkg::OW'(iirbe_pkg::OP_FB)) begin
            s_b = 32'(r_xh[s_xi[iirbe_pkg::HW-1:0]]);
        end else if (i_tag.op == iirbe_pkg::OW'(iirbe_pkg::OP_GLO)) begin
            s_a = {2'b00, r_ff[21:0]};
            s_b = {16'b0, r_gain};
        end else if (i_tag.op == iirbe_pkg::OW'(iirbe_pkg::OP_GHI)) begin
            s_a = r_ff[45:22];
            s_b = {16'b0, r_gain};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            for (int i = 0; i < iirbe_pkg::HIST; i++) begin
                r_xh[i] <= '0;
            end
        end else if (i_start) begin
            r_x <= i_x;
        end else if (i_commit) begin
            r_xh[0] <= r_x;
            for (int i = 1; i < iirbe_pkg::HIST; i++) begin
                r_xh[i] <= r_xh[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2      <= '0;
            r_t3      <= '0;
            r_t4      <= '0;
            r_t5      <= '0;
            r_t6_last <= 1'b0;
        end else begin
            r_t2      <= i_tag;
            r_t3      <= '{vld:  r_t2.vld && (r_t2.op == iirbe_pkg::OW'(iirbe_pkg::OP_GHI)),
                           last: r_t2.last,
                           band: r_t2.band,
                           op:   r_t2.op};
            r_t4      <= r_t3;
            r_t5      <= r_t4;
            r_t6_last <= r_t5.vld && r_t5.last;
        end
    end

    assign s_p64 = 64'(r_prod);
    assign s_yr  = (r_acc + 64'sd524288) >>> 20;
    assign s_tr  = (r_total + 40'sd16) >>> 5;

    always_ff @(posedge i_clk) begin
        r_prod <= s_a * s_b;
        if (i_tag.vld && i_tag.op == iirbe_pkg::OW'(iirbe_pkg::OP_GAIN)) begin
            r_gain <= i_coef[15:0];
        end
        if (r_t2.vld) begin
            if (r_t2.op < iirbe_pkg::OW'(iirbe_pkg::OP_FB)) begin
                r_ff <= ((r_t2.op == iirbe_pkg::OW'(0)) ? 64'sd0 : r_ff) + s_p64;
            end else if (r_t2.op < iirbe_pkg::OW'(iirbe_pkg::OP_GAIN)) begin
                r_fb <= ((r_t2.op == iirbe_pkg::OW'(iirbe_pkg::OP_FB)) ? 64'sd0 : r_fb)
                        + s_p64;
            end else if (r_t2.op == iirbe_pkg::OW'(iirbe_pkg::OP_GLO)) begin
                r_glo <= s_p64;
            end else if (r_t2.op == iirbe_pkg::OW'(iirbe_pkg::OP_GHI)) begin
                r_gff <= r_glo + (s_p64 <<< 22);
            end
        end
        if (r_t3.vld) begin
            r_acc <= ((r_gff + 64'sd512) >>> 10) - r_fb;
        end
        if (r_t4.vld) begin
            if (s_yr > 64'sd2147483647) begin
                r_y <= 32'sh7fffffff;
            end else if (s_yr < -64'sd2147483648) begin
                r_y <= 32'sh80000000;
            end else begin
                r_y <= s_yr[31:0];
            end
        end
        if (r_t5.vld) begin
            r_total <= ((r_t5.band == '0) ? 40'sd0 : r_total) + 40'(r_y);
        end
    end

    assign o_ywr.vld  = r_t5.vld;
    assign o_ywr.band = r_t5.band;
    assign o_ywr.y    = r_y;

    always_comb begin
        o_res.vld     = r_t6_last;
        o_res.clipped = 1'b1;
        if (s_tr > 40'sd32767) begin
            o_res.sample = 16'sh7fff;
        end else if (s_tr < -40'sd32768) begin
            o_res.sample = 16'sh8000;
        end else begin
            o_res.sample  = s_tr[15:0];
            o_res.clipped = 1'b0;
        end
    end

endmodule
